>>> hdl/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

    // Input ops
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // ASCII bytes used by the escaper
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;

    // Command queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } out_item_t;

    // Work handed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,    // one literal byte
        CMD_PAIR = 2'd1,    // backslash + data[7:0]
        CMD_HEX  = 2'd2,    // backslash u + four hex digits of data
        CMD_ERR  = 2'd3     // single error result
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
    } cmd_t;

    // Queue handshake between the two halves
    typedef struct packed {
        logic push;
        logic full;
    } q_wr_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } q_rd_ctl_t;

    // Lower-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

>>> hdl/jse_front.sv
`timescale 1ns / 1ps

module jse_front
    import jse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    input  logic      q_full,
    output q_wr_ctl_t q_wr,
    output cmd_t      q_cmd
);

    logic        force_ucs2_reg;
    logic [15:0] partial_code_reg, partial_code_next;
    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic        accept;
    logic        push;
    logic [7:0]  b;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign b         = s_data.in_byte;

    assign q_wr.push = push;
    assign q_wr.full = q_full;

    // Classify the request and update the UTF-8 decode state
    always_comb begin
        partial_code_next  = partial_code_reg;
        bytes_pending_next = bytes_pending_reg;
        push               = 1'b0;
        q_cmd.kind         = CMD_BYTE;
        q_cmd.data         = 16'd0;
        if (accept) begin
            case (s_data.op)
                OP_BEGIN: begin
                    partial_code_next  = 16'd0;
                    bytes_pending_next = 2'd0;
                    push               = 1'b1;
                    q_cmd.data         = {8'd0, CH_QUOTE};
                end
                OP_END: begin
                    push = 1'b1;
                    if (bytes_pending_reg != 2'd0) begin
                        partial_code_next  = 16'd0;
                        bytes_pending_next = 2'd0;
                        q_cmd.kind         = CMD_ERR;
                    end else begin
                        q_cmd.data = {8'd0, CH_QUOTE};
                    end
                end
                OP_DATA: begin
                    if (bytes_pending_reg == 2'd2) begin
                        // middle byte of a three-byte sequence
                        partial_code_next  = partial_code_reg | {4'd0, b[5:0], 6'd0};
                        bytes_pending_next = 2'd1;
                    end else if (bytes_pending_reg != 2'd0) begin
                        // final continuation byte
                        partial_code_next  = 16'd0;
                        bytes_pending_next = 2'd0;
                        push               = 1'b1;
                        q_cmd.kind         = CMD_HEX;
                        q_cmd.data         = partial_code_reg | {10'd0, b[5:0]};
                    end else begin
                        push = 1'b1;
                        case (b)
                            CH_QUOTE: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_QUOTE};
                            end
                            CH_BSL: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_BSL};
                            end
                            CH_BS: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_LC_B};
                            end
                            CH_FF: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_LC_F};
                            end
                            CH_LF: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_LC_N};
                            end
                            CH_CR: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_LC_R};
                            end
                            CH_TAB: begin
                                q_cmd.kind = CMD_PAIR;
                                q_cmd.data = {8'd0, CH_LC_T};
                            end
                            default: begin
                                if (force_ucs2_reg && b[7]) begin
                                    if (b[7:5] == 3'b111) begin
                                        // three-byte lead, low four bits kept
                                        push               = 1'b0;
                                        partial_code_next  = {b[3:0], 12'd0};
                                        bytes_pending_next = 2'd2;
                                    end else if (b[7:5] == 3'b110) begin
                                        push               = 1'b0;
                                        partial_code_next  = {5'd0, b[4:0], 6'd0};
                                        bytes_pending_next = 2'd1;
                                    end else begin
                                        // stray continuation byte
                                        q_cmd.kind = CMD_ERR;
                                    end
                                end else begin
                                    q_cmd.data = {8'd0, b};
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    // unused op: no result, state kept
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_ucs2_reg    <= 1'b0;
            partial_code_reg  <= 16'd0;
            bytes_pending_reg <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                force_ucs2_reg <= cfg_data;
            end
            partial_code_reg  <= partial_code_next;
            bytes_pending_reg <= bytes_pending_next;
        end
    end

endmodule

>>> hdl/jse_queue.sv
`timescale 1ns / 1ps

module jse_queue
    import jse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_wr_ctl_t wr,
    input  cmd_t      wr_cmd,
    input  q_rd_ctl_t rd,
    output cmd_t      rd_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push, do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = wr.push && !wr.full;
    assign do_pop  = rd.pop && !rd.empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/jse_back.sv
`timescale 1ns / 1ps

module jse_back
    import jse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      q_cmd,
    input  logic      q_empty,
    output q_rd_ctl_t q_rd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic       active_reg;
    cmd_t       cmd_reg;
    logic [2:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic       load;
    logic       final_byte;
    logic [2:0] last_idx;
    logic       pop;
    out_item_t  cur;
    logic [3:0] nib;

    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;
    assign load       = active_reg && (!out_valid_reg || m_ready);
    assign final_byte = (idx_reg == last_idx);
    assign pop        = !q_empty && (!active_reg || (load && final_byte));
    assign q_rd.pop   = pop;
    assign q_rd.empty = q_empty;

    // Index of the last byte of each command
    always_comb begin
        case (cmd_reg.kind)
            CMD_PAIR: last_idx = 3'd1;
            CMD_HEX:  last_idx = 3'd5;
            default:  last_idx = 3'd0;
        endcase
    end

    // Digit of the code point for the current position
    always_comb begin
        case (idx_reg)
            3'd2:    nib = cmd_reg.data[15:12];
            3'd3:    nib = cmd_reg.data[11:8];
            3'd4:    nib = cmd_reg.data[7:4];
            default: nib = cmd_reg.data[3:0];
        endcase
    end

    // Byte at the current position of the command
    always_comb begin
        cur.last  = final_byte;
        cur.error = 1'b0;
        unique case (cmd_reg.kind)
            CMD_BYTE: cur.out_byte = cmd_reg.data[7:0];
            CMD_PAIR: cur.out_byte = (idx_reg == 3'd0) ? CH_BSL : cmd_reg.data[7:0];
            CMD_HEX: begin
                if (idx_reg == 3'd0) begin
                    cur.out_byte = CH_BSL;
                end else if (idx_reg == 3'd1) begin
                    cur.out_byte = CH_LC_U;
                end else begin
                    cur.out_byte = hex_char(nib);
                end
            end
            CMD_ERR: begin
                cur.out_byte = 8'd0;
                cur.error    = 1'b1;
            end
            default: cur.out_byte = 8'd0;
        endcase
    end

    // Command sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= 3'd0;
        end else begin
            if (pop) begin
                active_reg <= 1'b1;
                idx_reg    <= 3'd0;
            end else if (load && final_byte) begin
                active_reg <= 1'b0;
            end else if (load) begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= q_cmd;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= cur;
        end
    end

endmodule

>>> hdl/json_string_escaper_unit.sv
`timescale 1ns / 1ps

// JSON string escaper. A begin request yields an opening quote, an end request a
// closing quote, and each data byte yields itself, a two-byte backslash escape,
// or (with force_ucs2 set, written through the cfg channel while idle, a rule
// for the user that the block does not enforce) a six-byte \uXXXX escape once
// its UTF-8 sequence is complete; stray continuation bytes and an end inside a
// sequence yield one error result. The front classifies one request per cycle,
// while the queue is not full, into a four-entry command queue; the back drains
// it into a command register and emits one byte per cycle, while m_ready is
// high, through a registered output, so a request yields 0, 1, 2 or 6 bytes
// (0 for a lead byte, a middle continuation byte or an unused op). Sustained
// rate is set by the output side: one byte per cycle while m_ready is high.
module json_string_escaper_unit
    import jse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    q_wr_ctl_t q_wr;
    q_rd_ctl_t q_rd;
    cmd_t      wr_cmd;
    cmd_t      rd_cmd;
    logic      q_full;
    logic      q_empty;

    jse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_cmd     (wr_cmd)
    );

    jse_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_cmd  (wr_cmd),
        .rd      (q_rd),
        .rd_cmd  (rd_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    jse_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_cmd   (rd_cmd),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
